[hdl/rqf_pkg.sv]
// Package for the ring queue: payload types, operation and status codes, index helpers.
package rqf_pkg;

  // Storage depth and the widths that follow from it.
  localparam int Depth = 64;
  localparam int IdxW  = 6;
  localparam int CntW  = 7;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_FIND       = 3'd3;
  localparam logic [2:0] KIND_CLEAR      = 3'd4;

  // Status codes of a result.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // Value answered by a pop on an empty queue.
  localparam logic [15:0] EMPTY_DATA = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        remove;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data;
    logic [6:0]  occupancy;
  } rsp_t;

  // Write request into the slot store.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [15:0]     data;
  } slot_wr_t;

  // Next index around the ring of cap slots.
  function automatic logic [IdxW-1:0] step_up(input logic [IdxW-1:0] i,
                                              input logic [CntW-1:0] cap);
    logic [CntW-1:0] inc;
    inc = {1'b0, i} + CntW'(1);
    return (inc >= cap) ? '0 : inc[IdxW-1:0];
  endfunction

  // Previous index around the ring of cap slots.
  function automatic logic [IdxW-1:0] step_down(input logic [IdxW-1:0] i,
                                                input logic [CntW-1:0] cap);
    logic [CntW-1:0] top;
    top = cap - CntW'(1);
    return (i == '0 || {1'b0, i} >= cap) ? top[IdxW-1:0] : i - IdxW'(1);
  endfunction

endpackage

[hdl/rqf_slots.sv]
// Slot store of the ring queue: one write port, one read port with registered data.
module rqf_slots (
  input  logic                           clk,
  input  rqf_pkg::slot_wr_t              wr,
  input  logic [rqf_pkg::IdxW-1:0]       rd_addr,
  output logic [15:0]                    rd_data
);
  import rqf_pkg::*;

  logic [15:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/ring_queue_with_front_push_and_find_core.sv]
// Top level of the ring queue: sequencer, index registers, compare unit and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  req     | in        | req_valid/req_stall | kind, value, remove
//  rsp     | out       | rsp_valid/rsp_stall | status, data, occupancy
//  cfg     | in        | cfg_valid/cfg_ready | capacity (7 bits)
//
// Pushes, pops and clear pass from the idle state through the execute state to the
// output state. A find also scans the held entries front to back in the scan state (up to
// the capacity), one per cycle through the single read port of the slot store, and passes
// through the move state when a match in the middle is replaced by the back entry.
// Reset leaves the queue empty with capacity 64; slot contents are not cleared.
// A stalled result holds the sequencer before the next item is taken.
module ring_queue_with_front_push_and_find_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rqf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rqf_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);
  import rqf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t          state, state_next;
  req_t            item;
  logic [IdxW-1:0] head, head_next;
  logic [IdxW-1:0] tail, tail_next;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] cap;
  logic [IdxW-1:0] pos, pos_next;
  logic [CntW-1:0] scan_n, scan_n_next;
  logic [1:0]      res_status, res_status_next;
  logic [15:0]     res_data, res_data_next;

  slot_wr_t        wr;
  logic [IdxW-1:0] rd_addr;
  logic [15:0]     rd_data;

  logic            req_xfer;
  logic            cfg_xfer;
  logic            rsp_free;
  logic            hit;
  logic [CntW-1:0] cap_wr;
  logic [CntW-1:0] cap_top;

  rqf_slots u_slots (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshakes: configuration wins over an item offered in the same idle cycle.
  assign cfg_ready = (state == S_IDLE);
  assign req_stall = (state != S_IDLE) || cfg_valid;
  assign req_xfer  = req_valid && !req_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Clamp a written capacity into 1..Depth.
  always_comb begin
    if (cfg_data == '0) begin
      cap_wr = CntW'(1);
    end else if (cfg_data > CntW'(Depth)) begin
      cap_wr = CntW'(Depth);
    end else begin
      cap_wr = cfg_data;
    end
  end

  assign cap_top = cap - CntW'(1);

  // The shared compare unit: current slot against the searched value.
  assign hit = (rd_data == item.value);

  // Read address: the front outside the scan state, the next slot or the back entry while scanning.
  always_comb begin
    unique case (state)
      S_SCAN: begin
        if (hit && item.remove && scan_n != '0) begin
          rd_addr = tail;
        end else begin
          rd_addr = step_up(pos, cap);
        end
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  // Sequencer and next values of the queue registers.
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    pos_next        = pos;
    scan_n_next     = scan_n;
    res_status_next = res_status;
    res_data_next   = res_data;
    wr.en           = 1'b0;
    wr.addr         = pos;
    wr.data         = rd_data;

    unique case (state)
      S_IDLE: begin
        if (cfg_xfer) begin
          head_next  = '0;
          tail_next  = IdxW'(cap_wr - CntW'(1));
          count_next = '0;
        end else if (req_xfer) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_next = STAT_OK;
        res_data_next   = '0;
        state_next      = S_OUT;
        unique case (item.kind)
          KIND_PUSH_BACK: begin
            if (count >= cap) begin
              res_status_next = STAT_FULL;
            end else begin
              tail_next  = step_up(tail, cap);
              wr.en      = 1'b1;
              wr.addr    = step_up(tail, cap);
              wr.data    = item.value;
              count_next = count + CntW'(1);
            end
          end
          KIND_PUSH_FRONT: begin
            // The back index already equals front + count - 1, so it stays put.
            if (count >= cap) begin
              res_status_next = STAT_FULL;
            end else begin
              head_next  = step_down(head, cap);
              wr.en      = 1'b1;
              wr.addr    = step_down(head, cap);
              wr.data    = item.value;
              count_next = count + CntW'(1);
            end
          end
          KIND_POP_FRONT: begin
            // The front slot was read on the transfer edge.
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              res_data_next   = EMPTY_DATA;
            end else begin
              res_data_next = rd_data;
              head_next     = step_up(head, cap);
              count_next    = count - CntW'(1);
            end
          end
          KIND_FIND: begin
            res_status_next = STAT_NOT_FOUND;
            if (count != '0) begin
              pos_next    = head;
              scan_n_next = '0;
              state_next  = S_SCAN;
            end
          end
          KIND_CLEAR: begin
            head_next  = '0;
            tail_next  = cap_top[IdxW-1:0];
            count_next = '0;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // One held entry is compared per cycle, front to back.
        if (hit) begin
          res_status_next = STAT_OK;
          if (item.remove && scan_n == '0) begin
            head_next  = step_up(head, cap);
            count_next = count - CntW'(1);
            state_next = S_OUT;
          end else if (item.remove) begin
            state_next = S_MOVE;
          end else begin
            state_next = S_OUT;
          end
        end else if (scan_n + CntW'(1) == count) begin
          state_next = S_OUT;
        end else begin
          scan_n_next = scan_n + CntW'(1);
          pos_next    = step_up(pos, cap);
        end
      end

      S_MOVE: begin
        // The back entry fills the hole and the back index steps back.
        wr.en      = 1'b1;
        wr.addr    = pos;
        wr.data    = rd_data;
        count_next = count - CntW'(1);
        tail_next  = step_down(tail, cap);
        state_next = S_OUT;
      end

      S_OUT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= IdxW'(Depth - 1);
      count     <= '0;
      cap       <= CntW'(Depth);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (cfg_xfer) begin
        cap <= cap_wr;
      end
      if (state == S_OUT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item <= req;
    end
    pos        <= pos_next;
    scan_n     <= scan_n_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    if (state == S_OUT && rsp_free) begin
      rsp.status    <= res_status;
      rsp.data      <= res_data;
      rsp.occupancy <= count;
    end
  end

endmodule

[verif/ring_queue_with_front_push_and_find_core_tb.sv]
// Self-checking testbench for the ring queue core: directed and random items against a predictor.
`timescale 1ns / 1ps

module ring_queue_with_front_push_and_find_core_tb;
  import rqf_pkg::*;

  // Kinds with no operation behind them.
  localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
  localparam logic [2:0] KIND_LAST_SPARE  = 3'd7;

  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 97;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_PRINTED     = 100;

  // Predicts each result from the accepted requests and checks what comes back.
  class deque_scoreboard;
    logic [15:0] slot_copy [Depth];
    int unsigned front_idx;
    int unsigned back_idx;
    int unsigned held;
    int unsigned cap_setting;
    rsp_t        expected_rsps [$];
    int          error_count;
    int          results_checked;

    function new();
      cap_setting     = Depth;
      error_count     = 0;
      results_checked = 0;
      empty_ring();
    endfunction

    // Out-of-range capacities are clamped into 1..Depth.
    function int unsigned eff_cap();
      if (cap_setting < 1) return 1;
      if (cap_setting > Depth) return Depth;
      return cap_setting;
    endfunction

    function int unsigned ring_up(int unsigned i, int unsigned c);
      return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function int unsigned ring_down(int unsigned i, int unsigned c);
      return (i == 0 || i >= c) ? c - 1 : i - 1;
    endfunction

    function void empty_ring();
      front_idx = 0;
      back_idx  = eff_cap() - 1;
      held      = 0;
    endfunction

    // A capacity write also empties the queue.
    function void set_capacity(logic [6:0] v);
      cap_setting = v;
      empty_ring();
    endfunction

    function logic [15:0] take_front(int unsigned c);
      logic [15:0] v;
      v         = slot_copy[front_idx % c];
      front_idx = ring_up(front_idx % c, c);
      held--;
      return v;
    endfunction

    function rsp_t predict_response(req_t r);
      rsp_t        e;
      int unsigned c;
      int unsigned pos;
      int unsigned n;
      bit          found;
      c        = eff_cap();
      e.status = STAT_OK;
      e.data   = '0;
      unique case (r.kind)
        KIND_PUSH_BACK: begin
          if (held >= c) begin
            e.status = STAT_FULL;
          end else begin
            back_idx            = ring_up(back_idx % c, c);
            slot_copy[back_idx] = r.value;
            held++;
          end
        end
        KIND_PUSH_FRONT: begin
          if (held >= c) begin
            e.status = STAT_FULL;
          end else begin
            front_idx            = ring_down(front_idx % c, c);
            slot_copy[front_idx] = r.value;
            held++;
            back_idx = (front_idx + held - 1) % c;
          end
        end
        KIND_POP_FRONT: begin
          if (held == 0) begin
            e.status = STAT_EMPTY;
            e.data   = EMPTY_DATA;
          end else begin
            e.data = take_front(c);
          end
        end
        KIND_FIND: begin
          // Scan front to back; a middle match is replaced by the back entry.
          pos      = front_idx % c;
          e.status = STAT_NOT_FOUND;
          found    = 1'b0;
          for (n = 0; n < held && !found; n++) begin
            if (slot_copy[pos] == r.value) begin
              found    = 1'b1;
              e.status = STAT_OK;
              if (r.remove) begin
                if (n == 0) begin
                  void'(take_front(c));
                end else begin
                  slot_copy[pos] = slot_copy[back_idx % c];
                  held--;
                  back_idx = ring_down(back_idx % c, c);
                end
              end
            end else begin
              pos = ring_up(pos, c);
            end
          end
        end
        KIND_CLEAR: empty_ring();
        default: ;
      endcase
      e.occupancy = 7'(held);
      return e;
    endfunction

    function void note_request(req_t r);
      expected_rsps.push_back(predict_response(r));
    endfunction

    task report_mismatch(string what, int got, int want);
      if (error_count < MAX_PRINTED) begin
        $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
      end
      error_count++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      results_checked++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("result with nothing expected", got, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.data !== want.data) report_mismatch("data", got.data, want.data);
        if (got.occupancy !== want.occupancy) begin
          report_mismatch("occupancy", got.occupancy, want.occupancy);
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  deque_scoreboard sb;
  bit idle_on;
  int quiet_cycles;

  ring_queue_with_front_push_and_find_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample every transfer at the rising edge and hand it to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
    end
  end

  // End the run when no transfer of any kind happens for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, and one long hold-off that backs up the block.
  initial begin : result_side
    bit held_off;
    held_off  = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb != null && sb.results_checked >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        rsp_stall <= idle_on && ($urandom_range(99) < 11);
      end
    end
  end

  function automatic req_t make_req(logic [2:0] k, logic [15:0] v, logic rm);
    req_t r;
    r.kind   = k;
    r.value  = v;
    r.remove = rm;
    return r;
  endfunction

  // Random item; values come mostly from a small set so finds hit duplicates.
  function automatic req_t random_request(int push_pct);
    logic [2:0]  k;
    logic [15:0] v;
    int          s;
    s = $urandom_range(99);
    if (s < 60) v = 16'($urandom_range(7));
    else if (s < 70) v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else v = 16'($urandom);
    if ($urandom_range(99) < push_pct) begin
      k = ($urandom_range(99) < 60) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    end else begin
      s = $urandom_range(99);
      if (s < 45) k = KIND_POP_FRONT;
      else if (s < 88) k = KIND_FIND;
      else if (s < 92) k = KIND_CLEAR;
      else k = 3'($urandom_range(KIND_LAST_SPARE, KIND_FIRST_SPARE));
    end
    if (k == KIND_FIND && sb.held != 0 && $urandom_range(99) < 60) begin
      v = sb.slot_copy[(sb.front_idx + $urandom_range(sb.held - 1)) % sb.eff_cap()];
    end
    return make_req(k, v, 1'($urandom_range(1)));
  endfunction

  // Offer one item after an optional gap; returns at the falling edge after its transfer.
  task automatic send_item(input req_t r);
    while (idle_on && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [6:0] phase_cap [NUM_PHASES];
    int         phase_push [NUM_PHASES];
    int         p;
    phase_cap  = '{7'd2, 7'd0, 7'd5, 7'd127, 7'd3, 7'd64, 7'd1, 7'd100, 7'd16};
    phase_push = '{60, 55, 65, 75, 50, 80, 50, 45, 60};
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    sb        = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items at the reset capacity: empty cases, both pushes, every kind of find, clear, spare kinds.
    send_item(make_req(KIND_POP_FRONT, 16'h0000, 1'b0));
    send_item(make_req(KIND_FIND, 16'h0000, 1'b1));
    send_item(make_req(KIND_PUSH_BACK, 16'h0000, 1'b1));
    send_item(make_req(KIND_PUSH_BACK, 16'hFFFF, 1'b0));
    send_item(make_req(KIND_PUSH_FRONT, 16'h1234, 1'b1));
    send_item(make_req(KIND_FIND, 16'hFFFF, 1'b0));
    send_item(make_req(KIND_FIND, 16'h1234, 1'b1));
    send_item(make_req(KIND_PUSH_BACK, 16'h0005, 1'b0));
    send_item(make_req(KIND_PUSH_BACK, 16'h0006, 1'b0));
    send_item(make_req(KIND_FIND, 16'hFFFF, 1'b1));
    send_item(make_req(KIND_FIND, 16'h0006, 1'b1));
    send_item(make_req(KIND_FIND, 16'h0005, 1'b1));
    send_item(make_req(KIND_FIND, 16'h0009, 1'b1));
    send_item(make_req(KIND_POP_FRONT, 16'hFFFF, 1'b1));
    send_item(make_req(KIND_POP_FRONT, 16'h0077, 1'b1));
    send_item(make_req(KIND_PUSH_FRONT, 16'hAAAA, 1'b0));
    send_item(make_req(KIND_PUSH_BACK, 16'h5555, 1'b1));
    send_item(make_req(KIND_CLEAR, 16'hFFFF, 1'b1));
    send_item(make_req(KIND_FIRST_SPARE, 16'hFFFF, 1'b1));
    send_item(make_req(KIND_FIRST_SPARE + 3'd1, 16'h8001, 1'b0));
    send_item(make_req(KIND_LAST_SPARE, 16'h7FFE, 1'b1));
    send_item(make_req(KIND_POP_FRONT, 16'h0000, 1'b0));

    // Single slot: both pushes refused once it holds an entry.
    wait_until_drained();
    write_capacity(7'd1);
    send_item(make_req(KIND_PUSH_FRONT, 16'h0001, 1'b0));
    send_item(make_req(KIND_PUSH_BACK, 16'h0002, 1'b0));
    send_item(make_req(KIND_PUSH_FRONT, 16'h0003, 1'b0));
    send_item(make_req(KIND_FIND, 16'h0001, 1'b0));
    send_item(make_req(KIND_POP_FRONT, 16'h0000, 1'b0));

    // Random phases over several capacities; one phase runs with no idling at all.
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_until_drained();
      if (p == NUM_PHASES - 1) write_capacity(7'($urandom_range(63, 4)));
      else write_capacity(phase_cap[p]);
      idle_on = (p != 5);
      repeat (ITEMS_PER_PHASE) send_item(random_request(phase_push[p]));
    end
    idle_on = 1'b1;
    wait_until_drained();

    if (sb.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rqf_pkg.sv
hdl/rqf_slots.sv
hdl/ring_queue_with_front_push_and_find_core.sv
verif/ring_queue_with_front_push_and_find_core_tb.sv
